// File: rtl/core/ihc_pkg.sv
// ihc_pkg: shared types and constants of the IPv4 header check block.
// No dependencies; every other file of the block uses it.
`default_nettype none

package ihc_pkg;

  localparam int unsigned HDR_WORDS = 10;
  localparam logic [3:0] IPV4_VERSION = 4'd4;
  localparam logic [15:0] WORD_MASK = 16'hFFFF;
  localparam int unsigned OUT_CNT_BITS = 32;

  typedef enum logic [2:0] {
    V_ACCEPTED     = 3'd0,
    V_TOO_SHORT    = 3'd1,
    V_BAD_VERSION  = 3'd2,
    V_TTL_ZERO     = 3'd3,
    V_BAD_CHECKSUM = 3'd4
  } verdict_t;

  // one registered frame word
  typedef struct packed {
    logic [15:0] header_word;
    logic        end_of_frame;
  } word_t;

  // one verdict as it travels to the result register
  typedef struct packed {
    verdict_t                  verdict;
    logic [7:0]                protocol;
    logic [OUT_CNT_BITS-1:0]   error_total;
    logic [OUT_CNT_BITS-1:0]   drop_total;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/ihc_if.sv
// ihc_in_if / ihc_out_if: valid-ready channels of the IPv4 header check.
// Depends on ihc_pkg for the verdict type.
`default_nettype none

interface ihc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] header_word;
  logic        end_of_frame;

  modport source (output valid, output header_word, output end_of_frame, input ready);
  modport sink   (input valid, input header_word, input end_of_frame, output ready);
endinterface

interface ihc_out_if;
  logic              valid;
  logic              ready;
  ihc_pkg::verdict_t verdict;
  logic [7:0]        protocol;
  logic [31:0]       error_total;
  logic [31:0]       drop_total;

  modport source (output valid, output verdict, output protocol, output error_total,
                  output drop_total, input ready);
  modport sink   (input valid, input verdict, input protocol, input error_total,
                  input drop_total, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ipv4_header_check_top.sv
// ipv4_header_check_top: IPv4 header checksum and field check over a word stream.
// Depends on ihc_pkg, ihc_if, ihc_in_stage, ihc_check and ihc_out_stage.
//
//  channel  | dir | requests carry                              | handshake
//  ---------+-----+---------------------------------------------+-------------------
//  in_ch    | in  | header_word[15:0], end_of_frame             | valid/ready
//  out_ch   | out | verdict[2:0], protocol[7:0], error_total,   | valid/ready
//           |     | drop_total (32 bits each)                   |
//
// One word request per cycle, sustained while out_ch takes its verdicts; a word is
// held in the input register, checked, and its verdict is loaded into the result
// register, from which out_ch takes it. The 16-bit add with end-around fold in
// ihc_check sits between the input and result registers.
// Reset (rst_n low, synchronous) empties both registers and clears frame state
// and counters. A verdict waiting in the result register holds the word behind it
// in the input register; one more word can enter an empty input register, then the
// input stalls until the verdict is taken.
`default_nettype none

module ipv4_header_check_top #(
  parameter int unsigned COUNTER_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ihc_in_if.sink     in_ch,
  ihc_out_if.source  out_ch
);

  logic             word_valid;
  ihc_pkg::word_t   word;
  logic             out_free;
  logic             adv;
  logic             res_valid;
  ihc_pkg::result_t res;

  // the registered word moves through the check when the result slot can take
  // whatever it may produce
  assign adv = word_valid && out_free;

  ihc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .adv        (adv),
    .word_valid (word_valid),
    .word       (word)
  );

  ihc_check #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .word      (word),
    .res_valid (res_valid),
    .res       (res)
  );

  ihc_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (adv && res_valid),
    .res      (res),
    .out_ch   (out_ch),
    .out_free (out_free)
  );

endmodule

`default_nettype wire

// File: rtl/core/ihc_in_stage.sv
// ihc_in_stage: input register of the header check, one word deep.
// Depends on ihc_pkg and ihc_in_if.
`default_nettype none

module ihc_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  ihc_in_if.sink              in_ch,
  input  wire logic           adv,
  output logic                word_valid,
  output ihc_pkg::word_t      word
);

  logic           valid_r;
  ihc_pkg::word_t word_r;
  logic           take;

  assign in_ch.ready = !valid_r || adv;
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (adv) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word_r.header_word  <= in_ch.header_word;
      word_r.end_of_frame <= in_ch.end_of_frame;
    end
  end

  assign word_valid = valid_r;
  assign word       = word_r;

endmodule

`default_nettype wire

// File: rtl/core/ihc_check.sv
// ihc_check: frame state, folded ones' complement sum and verdict logic.
// Depends on ihc_pkg.
`default_nettype none

module ihc_check #(
  parameter int unsigned COUNTER_BITS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  ihc_pkg::word_t      word,
  output logic                res_valid,
  output ihc_pkg::result_t    res
);

  localparam logic [COUNTER_BITS-1:0] CNT_ONE = {{(COUNTER_BITS-1){1'b0}}, 1'b1};

  logic [3:0]              word_idx_r, word_idx_nxt;
  logic [16:0]             sum_r, sum_nxt;
  logic                    ver_bad_r, ver_bad_nxt;
  logic                    ttl_zero_r, ttl_zero_nxt;
  logic [7:0]              proto_r, proto_nxt;
  logic                    skip_r, skip_nxt;
  logic [COUNTER_BITS-1:0] err_r, err_nxt;
  logic [COUNTER_BITS-1:0] drop_r, drop_nxt;

  logic [3:0]  idx_inc;
  logic [17:0] raw_sum;
  logic [16:0] fold_sum;
  logic        vb, tz;
  logic [7:0]  pb;
  logic [63:0] err_ext, drop_ext;

  ihc_pkg::verdict_t res_verdict;
  logic [7:0]        res_protocol;

  assign idx_inc  = word_idx_r + 4'd1;
  assign raw_sum  = {1'b0, sum_r} + {2'b00, word.header_word};
  assign fold_sum = {1'b0, raw_sum[15:0]} + {15'd0, raw_sum[17:16]};
  assign vb = (word_idx_r == 4'd0) ? (word.header_word[15:12] != ihc_pkg::IPV4_VERSION)
                                   : ver_bad_r;
  assign tz = (word_idx_r == 4'd4) ? (word.header_word[15:8] == 8'd0) : ttl_zero_r;
  assign pb = (word_idx_r == 4'd4) ? word.header_word[7:0] : proto_r;

  always_comb begin
    word_idx_nxt = word_idx_r;
    sum_nxt      = sum_r;
    ver_bad_nxt  = ver_bad_r;
    ttl_zero_nxt = ttl_zero_r;
    proto_nxt    = proto_r;
    skip_nxt     = skip_r;
    err_nxt      = err_r;
    drop_nxt     = drop_r;
    res_valid    = 1'b0;
    res_verdict  = ihc_pkg::V_ACCEPTED;
    res_protocol = 8'd0;

    if (skip_r) begin
      if (word.end_of_frame) begin
        skip_nxt = 1'b0;
      end
    end else if (idx_inc < 4'(ihc_pkg::HDR_WORDS)) begin
      if (word.end_of_frame) begin
        // frame ended inside the header
        res_valid    = 1'b1;
        res_verdict  = ihc_pkg::V_TOO_SHORT;
        word_idx_nxt = 4'd0;
        sum_nxt      = 17'd0;
        ver_bad_nxt  = 1'b0;
        ttl_zero_nxt = 1'b0;
        proto_nxt    = 8'd0;
      end else begin
        word_idx_nxt = idx_inc;
        sum_nxt      = fold_sum;
        ver_bad_nxt  = vb;
        ttl_zero_nxt = tz;
        proto_nxt    = pb;
      end
    end else begin
      res_valid = 1'b1;
      if (vb) begin
        res_verdict = ihc_pkg::V_BAD_VERSION;
        err_nxt     = err_r + CNT_ONE;
      end else if (tz) begin
        res_verdict = ihc_pkg::V_TTL_ZERO;
        drop_nxt    = drop_r + CNT_ONE;
      end else if (fold_sum[15:0] != ihc_pkg::WORD_MASK) begin
        res_verdict = ihc_pkg::V_BAD_CHECKSUM;
        err_nxt     = err_r + CNT_ONE;
      end else begin
        res_verdict  = ihc_pkg::V_ACCEPTED;
        res_protocol = pb;
      end
      skip_nxt     = !word.end_of_frame;
      word_idx_nxt = 4'd0;
      sum_nxt      = 17'd0;
      ver_bad_nxt  = 1'b0;
      ttl_zero_nxt = 1'b0;
      proto_nxt    = 8'd0;
    end
  end

  assign err_ext  = 64'(err_nxt);
  assign drop_ext = 64'(drop_nxt);
  assign res      = {res_verdict, res_protocol,
                     err_ext[ihc_pkg::OUT_CNT_BITS-1:0],
                     drop_ext[ihc_pkg::OUT_CNT_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_idx_r <= 4'd0;
      sum_r      <= 17'd0;
      ver_bad_r  <= 1'b0;
      ttl_zero_r <= 1'b0;
      proto_r    <= 8'd0;
      skip_r     <= 1'b0;
      err_r      <= '0;
      drop_r     <= '0;
    end else if (adv) begin
      word_idx_r <= word_idx_nxt;
      sum_r      <= sum_nxt;
      ver_bad_r  <= ver_bad_nxt;
      ttl_zero_r <= ttl_zero_nxt;
      proto_r    <= proto_nxt;
      skip_r     <= skip_nxt;
      err_r      <= err_nxt;
      drop_r     <= drop_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ihc_out_stage.sv
// ihc_out_stage: result register driving the verdict channel.
// Depends on ihc_pkg and ihc_out_if.
`default_nettype none

module ihc_out_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  ihc_pkg::result_t    res,
  ihc_out_if.source           out_ch,
  output logic                out_free
);

  logic             valid_r;
  ihc_pkg::result_t res_r;

  assign out_free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.verdict     = res_r.verdict;
  assign out_ch.protocol    = res_r.protocol;
  assign out_ch.error_total = res_r.error_total;
  assign out_ch.drop_total  = res_r.drop_total;

endmodule

`default_nettype wire

// File: rtl/core/ihc_checker.sv
// ihc_checker: port-level assertions for ipv4_header_check_top, bound to it.
// Depends on ihc_pkg.
`default_nettype none

module ihc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_verdict,
  input wire logic [7:0]  out_protocol
);

  // a pending verdict stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("verdict dropped while stalled");

  // only the defined verdict codes appear
  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict <= 3'(ihc_pkg::V_BAD_CHECKSUM)))
    else $error("undefined verdict code");

  // protocol is reported for accepted headers only
  a_proto_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict != 3'(ihc_pkg::V_ACCEPTED)) |-> (out_protocol == 8'd0))
    else $error("protocol set on a rejected frame");

  // nothing is offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("verdict offered after reset");

endmodule

bind ipv4_header_check_top ihc_checker u_ihc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_verdict  (out_ch.verdict),
  .out_protocol (out_ch.protocol)
);

`default_nettype wire

// File: tb/sv/ipv4_header_check_top_test.sv
`timescale 1ns / 1ps
// ipv4_header_check_top_test: self-checking bench for the IPv4 header check block.
// Needs ihc_pkg, ihc_if and the block's RTL; drives word requests and checks verdicts.

module ipv4_header_check_top_test;
  import ihc_pkg::*;

  localparam int unsigned COUNTER_BITS = 32;
  localparam int unsigned WORD_TARGET  = 1700;      // random word requests to send
  localparam int unsigned CYCLE_LIMIT  = 200000;    // watchdog, far beyond a slow run
  localparam int unsigned SETTLE       = 8;         // cycles after the last verdict
  localparam int unsigned SHOW_LIMIT   = 10;        // mismatches printed in full

  // one row of the directed table; res is only used where typed is set
  typedef struct {
    logic [15:0] word;
    logic        eof;
    bit          typed;
    result_t     res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ihc_in_if  in_ch ();
  ihc_out_if out_ch ();

  ipv4_header_check_top #(
    .COUNTER_BITS(COUNTER_BITS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the frame tracking and the wrapping counters.
  // ---------------------------------------------------------------------------
  logic [3:0]              hdr_count  = '0;    // header words taken in this frame
  logic [16:0]             hdr_sum    = '0;    // folded ones' complement sum so far
  logic                    ver_bad    = 1'b0;
  logic                    ttl_zero   = 1'b0;
  logic [7:0]              proto_seen = '0;
  logic                    in_trailer = 1'b0;  // skipping words after a full header
  logic [COUNTER_BITS-1:0] err_cnt    = '0;
  logic [COUNTER_BITS-1:0] drop_cnt   = '0;

  result_t     pending_verdicts[$];       // verdicts still owed by the block
  stim_row_t   stim_rows[$];
  logic [15:0] good_hdr [10];

  int          word_row;                  // directed row on the input, -1 when random
  bit          no_idle;                   // both sides run flat out while set
  int unsigned cycle_count = 0;
  int unsigned words_sent;
  int unsigned frames_sent;
  int unsigned verdicts_checked = 0;
  int unsigned fault_count = 0;
  int unsigned verdict_seen [5] = '{default: 0};

  // end-around-carry add of one word into the running sum
  function automatic logic [16:0] fold_add(logic [16:0] acc, logic [15:0] w);
    logic [17:0] s;
    s = {1'b0, acc} + {2'b00, w};
    s = {2'b00, s[15:0]} + {16'd0, s[17:16]};
    return s[16:0];
  endfunction

  // Works out what one accepted word request does to the frame state, and the
  // verdict it raises, if any. Check order: short, version, TTL, checksum.
  task automatic predict_verdict(input logic [15:0] w, input logic eof,
                                 output bit fired, output result_t r);
    fired = 1'b0;
    r     = '0;
    if (in_trailer) begin
      if (eof) in_trailer = 1'b0;
      return;
    end
    if (hdr_count == 4'd0) ver_bad = (w[15:12] != IPV4_VERSION);
    if (hdr_count == 4'd4) begin
      ttl_zero   = (w[15:8] == 8'h00);
      proto_seen = w[7:0];
    end
    hdr_sum   = fold_add(hdr_sum, w);
    hdr_count = hdr_count + 4'd1;

    if (hdr_count < HDR_WORDS) begin
      if (!eof) return;
      r.verdict = V_TOO_SHORT;
    end else if (ver_bad) begin
      r.verdict = V_BAD_VERSION;
      err_cnt   = err_cnt + 1'b1;
    end else if (ttl_zero) begin
      r.verdict = V_TTL_ZERO;
      drop_cnt  = drop_cnt + 1'b1;
    end else if (hdr_sum[15:0] != WORD_MASK) begin
      r.verdict = V_BAD_CHECKSUM;
      err_cnt   = err_cnt + 1'b1;
    end else begin
      r.verdict  = V_ACCEPTED;
      r.protocol = proto_seen;
    end
    r.error_total = err_cnt[31:0];
    r.drop_total  = drop_cnt[31:0];
    fired         = 1'b1;

    // a full header without end of frame leaves trailing words to skip
    if (hdr_count >= HDR_WORDS && !eof) in_trailer = 1'b1;
    hdr_count  = '0;
    hdr_sum    = '0;
    ver_bad    = 1'b0;
    ttl_zero   = 1'b0;
    proto_seen = '0;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: every check happens on the pre-edge values at the rising edge.
  // The verdict side is looked at first; a verdict never follows its word
  // within the same cycle, so the order of the two halves does not matter.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    result_t pred;
    bit      fired;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.verdict     = out_ch.verdict;
        got.protocol    = out_ch.protocol;
        got.error_total = out_ch.error_total;
        got.drop_total  = out_ch.drop_total;
        verdicts_checked++;
        if (int'(got.verdict) < 5) verdict_seen[int'(got.verdict)]++;
        if (pending_verdicts.size() == 0) begin
          if (fault_count < SHOW_LIMIT)
            $display("[%0d] verdict request with nothing owed: verdict %0d proto %02h",
                     cycle_count, got.verdict, got.protocol);
          fault_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (got.verdict !== want.verdict || got.protocol !== want.protocol ||
              got.error_total !== want.error_total || got.drop_total !== want.drop_total)
          begin
            if (fault_count < SHOW_LIMIT)
              $display("[%0d] verdict mismatch: want v%0d p%02h e%0d d%0d, got v%0d p%02h e%0d d%0d",
                       cycle_count, want.verdict, want.protocol, want.error_total,
                       want.drop_total, got.verdict, got.protocol, got.error_total,
                       got.drop_total);
            fault_count++;
          end
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        predict_verdict(in_ch.header_word, in_ch.end_of_frame, fired, pred);
        // hand-typed rows of the table take precedence over the predictor
        if (fired) begin
          if (word_row >= 0 && stim_rows[word_row].typed)
            pending_verdicts.push_back(stim_rows[word_row].res);
          else
            pending_verdicts.push_back(pred);
        end
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("watchdog: run stuck after %0d cycles, %0d verdicts owed",
             cycle_count, pending_verdicts.size());
    $display("FAIL ipv4_header_check_top");
    $finish;
  end

  // Receiver: ready drops about 16 percent of the time, except while no_idle is set.
  initial begin : receiver
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 16);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender tasks
  // ---------------------------------------------------------------------------

  // One word request: optional idle cycles first, then hold until taken.
  // Returns at the edge where the request was accepted.
  task automatic send_word(input logic [15:0] w, input logic eof, input int row);
    while (!no_idle && $urandom_range(0, 99) < 16) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.header_word  <= w;
    in_ch.end_of_frame <= eof;
    word_row           <= row;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // Sender holds off until the block owes nothing more.
  task automatic drain_verdicts();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic put_row(input logic [15:0] w, input logic eof, input bit typed,
                         input verdict_t v, input logic [7:0] p,
                         input logic [31:0] e, input logic [31:0] d);
    stim_row_t row;
    row.word            = w;
    row.eof             = eof;
    row.typed           = typed;
    row.res.verdict     = v;
    row.res.protocol    = p;
    row.res.error_total = e;
    row.res.drop_total  = d;
    stim_rows.push_back(row);
  endtask

  // Mostly well-formed headers with random content (right version, sound
  // checksum most of the time), some short frames and some raw noise. Every
  // frame closes with end of frame so the next one starts aligned.
  task automatic send_random_frame();
    logic [15:0] hdr [10];
    logic [16:0] acc;
    int          shape;
    int          n_extra;
    shape = $urandom_range(0, 99);
    if (shape < 75) begin
      for (int i = 0; i < 10; i++) hdr[i] = 16'($urandom);
      if ($urandom_range(0, 9) != 0) hdr[0][15:12] = IPV4_VERSION;
      if ($urandom_range(0, 7) == 0) hdr[4][15:8] = 8'h00;
      if ($urandom_range(0, 4) != 0) begin
        // checksum word is the complement of the sum of the other nine
        hdr[5] = 16'h0000;
        acc    = '0;
        for (int i = 0; i < 10; i++) acc = fold_add(acc, hdr[i]);
        hdr[5] = ~acc[15:0];
      end
      n_extra = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
      for (int i = 0; i < 10; i++) send_word(hdr[i], (i == 9) && (n_extra == 0), -1);
      for (int i = 0; i < n_extra; i++) send_word(16'($urandom), i == n_extra - 1, -1);
    end else if (shape < 90) begin
      n_extra = $urandom_range(1, 9);
      for (int i = 0; i < n_extra; i++)
        send_word((i == 0) ? {IPV4_VERSION, 12'($urandom)} : 16'($urandom),
                  i == n_extra - 1, -1);
    end else begin
      n_extra = $urandom_range(1, 16);
      for (int i = 0; i < n_extra; i++)
        send_word(16'($urandom), (i == n_extra - 1) || ($urandom_range(0, 5) == 0), -1);
    end
    frames_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.header_word  <= '0;
    in_ch.end_of_frame <= 1'b0;
    word_row           <= -1;
    no_idle     = 1'b0;
    words_sent  = 0;
    frames_sent = 0;

    // Directed table.
    // Too short on the very first word, widest word value.
    put_row(16'hFFFF, 1'b1, 1'b1, V_TOO_SHORT, 8'h00, 32'd0, 32'd0);
    // Sound header that ends at end of frame; TTL and protocol at their top.
    good_hdr = '{16'h4500, 16'h0014, 16'h0000, 16'h0000, 16'hFFFF,
                 16'hBAEB, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
    for (int i = 0; i < 10; i++)
      put_row(good_hdr[i], i == 9, i == 9, V_ACCEPTED, 8'hFF, 32'd0, 32'd0);
    // All-zero header: version is tested before the checksum, then one
    // trailing word is skipped.
    for (int i = 0; i < 10; i++)
      put_row(16'h0000, 1'b0, i == 9, V_BAD_VERSION, 8'h00, 32'd1, 32'd0);
    put_row(16'hFFFF, 1'b1, 1'b0, V_ACCEPTED, 8'h00, 32'd0, 32'd0);
    // Two-word frame right after the skip: block is aligned again.
    put_row(16'h4500, 1'b0, 1'b0, V_ACCEPTED, 8'h00, 32'd0, 32'd0);
    put_row(16'h0000, 1'b1, 1'b1, V_TOO_SHORT, 8'h00, 32'd1, 32'd0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) send_word(stim_rows[i].word, stim_rows[i].eof, i);
    drain_verdicts();

    // Random part (some 170 frames); frames 60-109 run with no idling at all,
    // and at frame 130 the sender waits for the block to settle.
    while (words_sent < WORD_TARGET + stim_rows.size()) begin
      no_idle = (frames_sent >= 60 && frames_sent < 110);
      if (frames_sent == 130) drain_verdicts();
      send_random_frame();
    end
    no_idle = 1'b0;

    drain_verdicts();
    repeat (SETTLE) @(posedge clk);

    $display("%0d word requests in %0d random frames after %0d directed rows, %0d verdicts checked",
             words_sent, frames_sent, stim_rows.size(), verdicts_checked);
    $display("verdicts: accepted %0d, too short %0d, bad version %0d, ttl zero %0d, bad checksum %0d",
             verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3], verdict_seen[4]);
    if (fault_count == 0 && pending_verdicts.size() == 0) begin
      $display("PASS ipv4_header_check_top");
    end else begin
      $display("%0d faults, %0d verdicts never arrived", fault_count, pending_verdicts.size());
      $display("FAIL ipv4_header_check_top");
    end
    $finish;
  end

endmodule
